>>> rtl/core/cwm_pkg.sv
// ----------------------------------------------------------------------------
// cwm_pkg: shared types and constants
// Sizes, result kinds, register indexes and the front-to-back record.
// ----------------------------------------------------------------------------
package cwm_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 65536;
	localparam int MAX_WINDOW  = 16;

	localparam int COL_W  = $clog2(MAX_COLUMNS);     // column index
	localparam int ROW_W  = $clog2(MAX_ROWS);        // row index
	localparam int SLOT_W = $clog2(MAX_WINDOW);      // window ring slot
	localparam int CCFG_W = 11;
	localparam int RCFG_W = 17;
	localparam int WCFG_W = 5;
	localparam int CNT_W  = 11;
	localparam int TOT_W  = 27;
	localparam int VAL_W  = 64;
	localparam int HIST_AW = SLOT_W + COL_W;
	localparam int NB_AW   = COL_W + 1;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		KIND_ROW    = 2'd0,
		KIND_COLMAX = 2'd1,
		KIND_TOTAL  = 2'd2,
		KIND_ERROR  = 2'd3
	} cwm_kind_t;

	localparam logic [1:0] CFG_COLUMNS = 2'd0;
	localparam logic [1:0] CFG_ROWS    = 2'd1;
	localparam logic [1:0] CFG_WINDOW  = 2'd2;

	// one accepted sample's worth of results
	typedef struct packed {
		logic               has_col;
		logic               has_prev;
		logic               has_cur;
		logic               has_fin;
		logic               fin_err;
		logic [COL_W-1:0]   col;
		logic [VAL_W-1:0]   col_max;
		logic [ROW_W-1:0]   row;
		logic [CNT_W-1:0]   prev_cnt;
		logic [CNT_W-1:0]   cur_cnt;
		logic [TOT_W-1:0]   total;
	} cwm_rec_t;

endpackage

>>> rtl/core/cwm_ram.sv
// ----------------------------------------------------------------------------
// cwm_ram: generic single-write, single-read RAM
// Registered read; a read and write at one address return the old data.
// ----------------------------------------------------------------------------
module cwm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
		if (we) mem[waddr] <= wdata;
	end

endmodule

>>> rtl/core/cwm_front.sv
// ----------------------------------------------------------------------------
// cwm_front: sample intake, window sums and peak detection
// Accept stage addresses the stores; stage 1 updates sums, maxima and counts
// and hands one record per result-bearing sample to the queue.
// ----------------------------------------------------------------------------
module cwm_front import cwm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [RCFG_W-1:0] cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [VAL_W-1:0]  s_tdata,
	input  logic [Q_AW:0]     q_count,
	output logic              push,
	output cwm_rec_t          rec
);

	logic [CCFG_W-1:0] cols_q;
	logic [RCFG_W-1:0] rows_q;
	logic [WCFG_W-1:0] wh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= CCFG_W'(1024);
			rows_q <= RCFG_W'(1024);
			wh_q   <= WCFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_COLUMNS: cols_q <= cfg_data[CCFG_W-1:0];
				CFG_ROWS:    rows_q <= cfg_data;
				CFG_WINDOW:  wh_q   <= cfg_data[WCFG_W-1:0];
				default:     ;
			endcase
		end
	end

	// accept stage
	logic [CCFG_W-1:0] cols_eff;
	logic [RCFG_W-1:0] rows_eff, r_cl;
	logic [WCFG_W-1:0] hw;
	logic [CCFG_W-1:0] c_cl;
	logic [COL_W-1:0]  col_q, c0;
	logic [ROW_W-1:0]  row_q, r0;
	logic [SLOT_W-1:0] slot_q;
	logic [WCFG_W-1:0] slot_inc;
	logic              err0, last_col0, last_row0, acc, s1_valid_q;

	always_comb begin
		if (cols_q == '0) cols_eff = CCFG_W'(1);
		else if (cols_q > CCFG_W'(MAX_COLUMNS)) cols_eff = CCFG_W'(MAX_COLUMNS);
		else cols_eff = cols_q;
		if (rows_q == '0) rows_eff = RCFG_W'(1);
		else if (rows_q > RCFG_W'(MAX_ROWS)) rows_eff = RCFG_W'(MAX_ROWS);
		else rows_eff = rows_q;
		hw   = (wh_q > WCFG_W'(MAX_WINDOW)) ? WCFG_W'(MAX_WINDOW) : wh_q;
		err0 = RCFG_W'(wh_q) > rows_eff;
		c_cl = ({1'b0, col_q} >= cols_eff) ? cols_eff - 1'b1 : {1'b0, col_q};
		r_cl = ({1'b0, row_q} >= rows_eff) ? rows_eff - 1'b1 : {1'b0, row_q};
		c0   = c_cl[COL_W-1:0];
		r0   = r_cl[ROW_W-1:0];
		last_col0 = (c_cl + 1'b1) == cols_eff;
		last_row0 = (r_cl + 1'b1) == rows_eff;
		slot_inc  = WCFG_W'(slot_q) + 1'b1;
	end

	assign s_tready = ({1'b0, q_count} + (Q_AW+2)'(s1_valid_q)) < (Q_AW+2)'(Q_DEPTH);
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (acc) begin
			if (last_col0) begin
				col_q <= '0;
				if (last_row0) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= r0 + 1'b1;
					slot_q <= (slot_inc == hw) ? '0 : slot_inc[SLOT_W-1:0];
				end
			end else begin
				row_q <= r0;
				col_q <= c0 + 1'b1;
			end
		end
	end

	// stores
	logic [VAL_W-1:0] hist_rd, nba_rd, nbb_rd, sum_rd, max_rd;
	logic [VAL_W-1:0] new_sum, new_max;
	logic [VAL_W-1:0] v_s1;
	logic [COL_W-1:0] c_s1;

	cwm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_WINDOW * MAX_COLUMNS)) u_hist (
		.clk, .we(acc && hw != '0), .waddr({slot_q, c0}), .wdata(s_tdata),
		.re(acc), .raddr({slot_q, c0}), .rdata(hist_rd));
	// two copies of the two-row buffer: one reads the row above, one the row before it
	cwm_ram #(.WIDTH(VAL_W), .DEPTH(2 * MAX_COLUMNS)) u_nb_a (
		.clk, .we(acc), .waddr({r0[0], c0}), .wdata(s_tdata),
		.re(acc), .raddr({~r0[0], c0}), .rdata(nba_rd));
	cwm_ram #(.WIDTH(VAL_W), .DEPTH(2 * MAX_COLUMNS)) u_nb_b (
		.clk, .we(acc), .waddr({r0[0], c0}), .wdata(s_tdata),
		.re(acc), .raddr({r0[0], c0}), .rdata(nbb_rd));
	cwm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_sum (
		.clk, .we(s1_valid_q), .waddr(c_s1), .wdata(new_sum),
		.re(acc), .raddr(c0), .rdata(sum_rd));
	cwm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_COLUMNS)) u_max (
		.clk, .we(s1_valid_q), .waddr(c_s1), .wdata(new_max),
		.re(acc), .raddr(c0), .rdata(max_rd));

	// stage 1 registers
	logic [ROW_W-1:0] r_s1;
	logic lc_s1, lr_s1, err_s1, hw0_s1, rge_s1, rfirst_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_valid_q <= 1'b0;
		else s1_valid_q <= acc;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			v_s1      <= s_tdata;
			c_s1      <= c0;
			r_s1      <= r0;
			lc_s1     <= last_col0;
			lr_s1     <= last_row0 && !err0 ? 1'b1 : last_row0;
			err_s1    <= err0;
			hw0_s1    <= (hw == '0);
			rge_s1    <= RCFG_W'(r0) >= RCFG_W'(hw);
			rfirst_s1 <= (RCFG_W'(r0) + 1'b1) == RCFG_W'(hw);
		end
	end

	// window sum and maximum, with bypass of the preceding sum and max write
	logic             fwd_valid_q;
	logic [COL_W-1:0] fwd_c_q;
	logic [VAL_W-1:0] fwd_sum_q, fwd_max_q, sum_old, max_old, s_base, s_new;
	logic             hit;

	always_comb begin
		hit     = fwd_valid_q && (fwd_c_q == c_s1);
		sum_old = hit ? fwd_sum_q : sum_rd;
		max_old = hit ? fwd_max_q : max_rd;
		s_base  = (r_s1 == '0) ? v_s1 : sum_old + v_s1;
		s_new   = s_base - (rge_s1 ? hist_rd : '0);
		if (hw0_s1) begin
			new_sum = '0;
			new_max = '0;
		end else begin
			new_sum = s_new;
			if (rfirst_s1) new_max = s_new;
			else if (rge_s1 && s_new > max_old) new_max = s_new;
			else new_max = max_old;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fwd_valid_q <= 1'b0;
		else fwd_valid_q <= s1_valid_q;
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			fwd_c_q   <= c_s1;
			fwd_sum_q <= new_sum;
			fwd_max_q <= new_max;
		end
	end

	// peaks: the row above is judged one sample late, once its right neighbor is read
	logic             pend_q;
	logic [VAL_W-1:0] a_prev_q, rv0_q, rv1_q;
	logic [CNT_W-1:0] prev_q, cur_q, prev_n, cur_n;
	logic [TOT_W-1:0] total_q, tot_a, tot_b;
	logic             ok_up, ok_fin, ok_cl, ok_cr, rpos, cpos;
	logic [1:0]       inc_p, inc_c;

	always_comb begin
		rpos   = (r_s1 != '0);
		cpos   = (c_s1 != '0);
		ok_up  = (nba_rd > v_s1) && (r_s1 <= ROW_W'(1) || nba_rd > nbb_rd)
			&& (!cpos || nba_rd > a_prev_q);
		ok_fin = cpos && pend_q && (a_prev_q > nba_rd);
		inc_p  = rpos ? (2'(ok_fin) + 2'(lc_s1 && ok_up)) : 2'd0;
		ok_cl  = cpos && (rv0_q > v_s1) && (c_s1 <= COL_W'(1) || rv0_q > rv1_q)
			&& (!rpos || rv0_q > a_prev_q);
		ok_cr  = lc_s1 && (!cpos || v_s1 > rv0_q) && (!rpos || v_s1 > nba_rd);
		inc_c  = lr_s1 ? (2'(ok_cl) + 2'(ok_cr)) : 2'd0;
		prev_n = prev_q + CNT_W'(inc_p);
		cur_n  = cur_q + CNT_W'(inc_c);
		tot_a  = total_q + (rpos ? TOT_W'(prev_n) : '0);
		tot_b  = tot_a + TOT_W'(cur_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= 1'b0;
			prev_q  <= '0;
			cur_q   <= '0;
			total_q <= '0;
		end else if (s1_valid_q) begin
			pend_q <= rpos && !lc_s1 && ok_up;
			if (lc_s1 && lr_s1) begin
				prev_q  <= '0;
				cur_q   <= '0;
				total_q <= '0;
			end else if (lc_s1) begin
				prev_q  <= rpos ? '0 : prev_n;
				cur_q   <= cur_n;
				total_q <= tot_a;
			end else begin
				prev_q <= prev_n;
				cur_q  <= cur_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q) begin
			a_prev_q <= nba_rd;
			rv0_q    <= v_s1;
			rv1_q    <= rv0_q;
		end
	end

	// result record
	always_comb begin
		rec          = '0;
		rec.col      = c_s1;
		rec.col_max  = new_max;
		rec.row      = r_s1;
		rec.prev_cnt = prev_n;
		rec.cur_cnt  = cur_n;
		rec.total    = tot_b;
		rec.has_col  = lr_s1 && !err_s1;
		if (lc_s1 && lr_s1) begin
			rec.has_fin  = 1'b1;
			rec.fin_err  = err_s1;
			rec.has_prev = !err_s1 && rpos;
			rec.has_cur  = !err_s1;
		end else if (lc_s1) begin
			rec.has_prev = !err_s1 && rpos;
		end
	end

	assign push = s1_valid_q && (rec.has_col || rec.has_prev || rec.has_cur || rec.has_fin);

endmodule

>>> rtl/core/cwm_queue.sv
// ----------------------------------------------------------------------------
// cwm_queue: record queue between front and back
// Small register FIFO; the front reserves room before accepting a sample.
// ----------------------------------------------------------------------------
module cwm_queue import cwm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cwm_rec_t      wdata,
	input  logic          pop,
	output cwm_rec_t      head,
	output logic          not_empty,
	output logic [Q_AW:0] count
);

	cwm_rec_t        buf_q [Q_DEPTH];
	logic [Q_AW-1:0] wp_q, rp_q;
	logic [Q_AW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= wdata;
	end

	assign head      = buf_q[rp_q];
	assign not_empty = (cnt_q != '0);
	assign count     = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != (Q_AW+1)'(Q_DEPTH)))
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");

endmodule

>>> rtl/core/cwm_back.sv
// ----------------------------------------------------------------------------
// cwm_back: result sequencer
// Walks the results of the head record in order into the output register.
// ----------------------------------------------------------------------------
module cwm_back import cwm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cwm_rec_t               head,
	input  logic                   not_empty,
	output logic                   pop,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [ROW_W+VAL_W-1:0] m_tdata,
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	logic [3:0] done_q, pend, pick;
	logic       load, valid_q;
	cwm_kind_t  kind;
	logic [ROW_W-1:0] idx;
	logic [VAL_W-1:0] val;

	always_comb begin
		pend = {head.has_fin, head.has_cur, head.has_prev, head.has_col} & ~done_q;
		pick = pend & (~pend + 1'b1);
		load = not_empty && (!valid_q || m_tready);
		pop  = load && ((pend & ~pick) == '0);
		kind = KIND_TOTAL;
		idx  = '0;
		val  = '0;
		priority if (pick[0]) begin
			kind = KIND_COLMAX;
			idx  = ROW_W'(head.col);
			val  = head.col_max;
		end else if (pick[1]) begin
			kind = KIND_ROW;
			idx  = head.row - 1'b1;
			val  = VAL_W'(head.prev_cnt);
		end else if (pick[2]) begin
			kind = KIND_ROW;
			idx  = head.row;
			val  = VAL_W'(head.cur_cnt);
		end else if (head.fin_err) begin
			kind = KIND_ERROR;
		end else begin
			val = VAL_W'(head.total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				done_q  <= pop ? '0 : (done_q | pick);
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {val, idx};
			m_tuser <= kind;
			m_tlast <= pick[3];
		end
	end

	assign m_tvalid = valid_q;

	a_pick_one: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> $onehot(pick))
		else $error("head record without pending result");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser == KIND_TOTAL || m_tuser == KIND_ERROR))
		else $error("frame end on wrong result kind");

endmodule

>>> rtl/core/column_window_max_and_peak_count.sv
// ----------------------------------------------------------------------------
// column_window_max_and_peak_count: column window maxima and peak counter
// Raster matrix in, per-row peak counts, per-column maximum window sums and
// the frame total out.
// ----------------------------------------------------------------------------
//  port group   dir  payload                                   transfer when
//  s_*          in   tdata[63:0] sample_value                  s_tvalid & s_tready
//  m_*          out  tdata: [15:0] index, [79:16] value;       m_tvalid & m_tready
//                    tuser[1:0] kind; tlast last of frame
//  cfg_*        in   index 0 columns, 1 rows, 2 window height  cfg_we
//
//  One sample per cycle sustained while s_tready is high. A sample passes the
//  accept stage (RAM read) and stage 1 (sum/compare/count) before its record is
//  queued. The frame's final sample yields up to four results, one per cycle out
//  of the back unless stalled; a four-entry queue lets the front keep taking samples
//  meanwhile. s_tready drops only when the queue plus the sample in flight would
//  fill it. Reset clears positions and counters; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module column_window_max_and_peak_count import cwm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [RCFG_W-1:0]      cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [VAL_W-1:0]       s_tdata,   // [63:0] sample_value
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [ROW_W+VAL_W-1:0] m_tdata,   // [15:0] result_index, [79:16] result_value
	output logic [1:0]             m_tuser,   // [1:0] result_kind
	output logic                   m_tlast
);

	cwm_rec_t      rec, head;
	logic          push, pop, not_empty;
	logic [Q_AW:0] q_count;

	// front: config, positions, window sums and peak logic
	cwm_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.s_tvalid, .s_tready, .s_tdata,
		.q_count, .push, .rec);

	// decouples the front from output stalls
	cwm_queue u_queue (
		.clk, .arst_n, .push, .wdata(rec), .pop,
		.head, .not_empty, .count(q_count));

	// back: one result per cycle into the output register while not stalled
	cwm_back u_back (
		.clk, .arst_n, .head, .not_empty, .pop,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output changed while stalled");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for column_window_max_and_peak_count
// Sends whole matrix frames over the sample stream, predicts every result with
// a behavioral copy of the column window and peak logic, and checks each
// result transfer in order, under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
module tb_top import cwm_pkg::*; ();

	typedef struct {
		cwm_kind_t   kind;
		logic [15:0] index;
		logic [63:0] value;
		logic        last;
	} result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [1:0]             cfg_index;
	logic [RCFG_W-1:0]      cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [VAL_W-1:0]       s_tdata;   // [63:0] sample_value
	logic                   m_tvalid;
	logic                   m_tready;
	logic [ROW_W+VAL_W-1:0] m_tdata;   // [15:0] result_index, [79:16] result_value
	logic [1:0]             m_tuser;   // [1:0] result_kind
	logic                   m_tlast;

	column_window_max_and_peak_count u_top (.*);

	// expected results, oldest first
	result_t expected_results[$];
	bit      failed;
	int      src_idle_pct;
	int      snk_stall_pct;

	// shadow registers, as written
	int unsigned reg_cols, reg_rows, reg_h;

	// shadow of the block's stores and counters
	logic [63:0] win_hist [MAX_WINDOW*MAX_COLUMNS];
	logic [63:0] nb_rows  [2*MAX_COLUMNS];
	logic [63:0] col_sum  [MAX_COLUMNS];
	logic [63:0] col_max  [MAX_COLUMNS];
	logic [63:0] recent   [2];
	int unsigned row_pos, col_pos, prev_pk, cur_pk, total_pk;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#80_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

	function automatic int unsigned eff_cols(int unsigned v);
		return (v == 0) ? 1 : (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
	endfunction

	function automatic int unsigned eff_rows(int unsigned v);
		return (v == 0) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
	endfunction

	function automatic void push_result(cwm_kind_t k, int unsigned idx, logic [63:0] val,
			logic lst);
		result_t r;
		r.kind  = k;
		r.index = idx[15:0];
		r.value = val;
		r.last  = lst;
		expected_results.push_back(r);
	endfunction

	// window sums, peak counts and result order for one accepted sample
	function automatic void predict_sample(logic [63:0] v);
		int unsigned cols, rows, hw, r, c, bcur, bprev, slot;
		bit err, last_col, last_row, ok;
		logic [63:0] ctr, s;
		cols = eff_cols(reg_cols);
		rows = eff_rows(reg_rows);
		err  = reg_h > rows;
		hw   = (reg_h > MAX_WINDOW) ? MAX_WINDOW : reg_h;
		r = (row_pos >= rows) ? rows - 1 : row_pos;
		c = (col_pos >= cols) ? cols - 1 : col_pos;
		last_col = (c + 1 == cols);
		last_row = (r + 1 == rows);

		// column window
		if (hw == 0) begin
			col_sum[c] = '0;
			col_max[c] = '0;
		end else begin
			slot = (r % hw) * MAX_COLUMNS + c;
			s = (r == 0) ? v : col_sum[c] + v;
			if (r >= hw)
				s = s - win_hist[slot];
			win_hist[slot] = v;
			col_sum[c] = s;
			if (r + 1 == hw)
				col_max[c] = s;
			else if (r >= hw && s > col_max[c])
				col_max[c] = s;
		end

		// peaks: row above is judged once its lower neighbor arrives
		bcur  = (r & 1) * MAX_COLUMNS;
		bprev = ((r + 1) & 1) * MAX_COLUMNS;
		if (r > 0) begin
			ctr = nb_rows[bprev + c];
			ok = ctr > v;
			if (ok && r > 1 && ctr <= nb_rows[bcur + c]) ok = 0;
			if (ok && c > 0 && ctr <= nb_rows[bprev + c - 1]) ok = 0;
			if (ok && !last_col && ctr <= nb_rows[bprev + c + 1]) ok = 0;
			if (ok) prev_pk++;
		end
		// last row has no lower neighbor: judged from the left
		if (last_row) begin
			if (c > 0) begin
				ctr = recent[0];
				ok = ctr > v;
				if (ok && c > 1 && ctr <= recent[1]) ok = 0;
				if (ok && r > 0 && ctr <= nb_rows[bprev + c - 1]) ok = 0;
				if (ok) cur_pk++;
			end
			if (last_col) begin
				ok = 1;
				if (c > 0 && v <= recent[0]) ok = 0;
				if (ok && r > 0 && v <= nb_rows[bprev + c]) ok = 0;
				if (ok) cur_pk++;
			end
		end
		nb_rows[bcur + c] = v;
		recent[1] = recent[0];
		recent[0] = v;

		if (last_row && !err)
			push_result(KIND_COLMAX, c, col_max[c], 1'b0);
		if (last_col) begin
			if (last_row) begin
				if (err) begin
					push_result(KIND_ERROR, 0, '0, 1'b1);
				end else begin
					if (r > 0) begin
						push_result(KIND_ROW, r - 1, prev_pk, 1'b0);
						total_pk = (total_pk + prev_pk) & 32'h7FF_FFFF;
					end
					push_result(KIND_ROW, r, cur_pk, 1'b0);
					total_pk = (total_pk + cur_pk) & 32'h7FF_FFFF;
					push_result(KIND_TOTAL, 0, total_pk, 1'b1);
				end
				row_pos  = 0;
				prev_pk  = 0;
				cur_pk   = 0;
				total_pk = 0;
			end else begin
				if (r > 0) begin
					if (!err)
						push_result(KIND_ROW, r - 1, prev_pk, 1'b0);
					total_pk = (total_pk + prev_pk) & 32'h7FF_FFFF;
					prev_pk = 0;
				end
				row_pos = r + 1;
			end
			col_pos = 0;
		end else begin
			row_pos = r;
			col_pos = c + 1;
		end
	endfunction

	// one sample transfer, with an optional idle gap in front
	task automatic send_sample(logic [63:0] v);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		predict_sample(v);
	endtask

	// wait until every expected result is out and the pipe has drained
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[RCFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_COLUMNS: reg_cols = val & 32'h7FF;
			CFG_ROWS:    reg_rows = val & 32'h1FFFF;
			default:     reg_h    = val & 32'h1F;
		endcase
	endtask

	function automatic logic [63:0] gen_value(int mode);
		case (mode)
			0: return 64'($urandom_range(3));
			1: return {$urandom, $urandom};
			default: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return {1'b1, 63'd0};
					default: return 64'($urandom_range(2));
				endcase
			end
		endcase
	endfunction

	// configure, then send one whole frame; a mid-frame hold is optional
	task automatic run_frame(int unsigned cols, int unsigned rows, int unsigned h, int mode,
			bit hold_mid = 0);
		int unsigned n;
		wait_drained();
		write_reg(CFG_COLUMNS, cols);
		write_reg(CFG_ROWS, rows);
		write_reg(CFG_WINDOW, h);
		n = eff_cols(reg_cols) * eff_rows(reg_rows);
		for (int unsigned i = 0; i < n; i++) begin
			if (hold_mid && i == n / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (expected_results.size() != 0);
			end
			send_sample(gen_value(mode));
		end
	endtask

	task automatic test_directed();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		run_frame(1, 1, 1, 2);         // single element frame
		run_frame(3, 3, 2, 0);         // small matrix, peaks likely
		run_frame(3, 2, 2, 2);         // extreme values, wrapping sums
		run_frame(2, 3, 0, 1);         // zero window height
		run_frame(2, 2, 3, 0);         // window taller than frame: error only
		run_frame(1, 20, 20, 0);       // window above the limit saturates
		run_frame(0, 0, 1, 2);         // zero sizes act as one
	endtask

	task automatic test_random(int src, int snk, int budget);
		int unsigned rows, h, cnt;
		src_idle_pct  = src;
		snk_stall_pct = snk;
		cnt = 0;
		while (cnt < budget) begin
			rows = $urandom_range(1, 5);
			h = ($urandom_range(9) == 0) ? rows + $urandom_range(1, 2) : $urandom_range(rows);
			run_frame($urandom_range(1, 5), rows, h, $urandom_range(2), cnt == 0);
			cnt += eff_cols(reg_cols) * eff_rows(reg_rows);
		end
	endtask

	// result checker and receiver stalls
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					failed = 1;
				end else begin
					e = expected_results.pop_front();
					if (m_tuser !== e.kind) begin
						$error("result_kind exp %0d got %0d", e.kind, m_tuser);
						failed = 1;
					end
					if (m_tdata[15:0] !== e.index) begin
						$error("result_index exp %0d got %0d", e.index, m_tdata[15:0]);
						failed = 1;
					end
					if (m_tdata[79:16] !== e.value) begin
						$error("result_value exp %0h got %0h", e.value, m_tdata[79:16]);
						failed = 1;
					end
					if (m_tlast !== e.last) begin
						$error("last_of_frame exp %0b got %0b", e.last, m_tlast);
						failed = 1;
					end
				end
			end
		end
	end

	initial begin
		failed = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COLUMNS;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		reg_cols = 1024;
		reg_rows = 1024;
		reg_h = 1;
		row_pos = 0;
		col_pos = 0;
		prev_pk = 0;
		cur_pk = 0;
		total_pk = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(0, 0, 18);
		test_random(65, 0, 18);
		test_random(0, 65, 18);
		test_random(35, 35, 18);

		wait_drained();
		if (!failed)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> column_window_max_and_peak_count.f
rtl/core/cwm_pkg.sv
rtl/core/cwm_ram.sv
rtl/core/cwm_front.sv
rtl/core/cwm_queue.sv
rtl/core/cwm_back.sv
rtl/core/column_window_max_and_peak_count.sv
verif/tb_top.sv
